### rtl/u8d_pkg.sv
// Shared types and constants for the UTF-8 byte decoder.
// No dependencies; used by the channel interfaces and all decoder modules.
`default_nettype none

package u8d_pkg;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned CODE_W     = 32;
   localparam int unsigned PARTIAL_W  = 31;
   localparam int unsigned COUNT_W    = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned CSR_ADDR_W = 3;

   localparam logic [CODE_W-1:0] REPLACEMENT_RESET = 32'h0000_FFFD;

   typedef enum logic [0:0] {
      REG_REPLACEMENT = 1'b0
   } reg_index_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_INVALID   = 2'd1,
      STATUS_TRUNCATED = 2'd2
   } status_type;

   typedef struct packed {
      logic [COUNT_W-1:0]   bytes_remaining;
      logic [COUNT_W-1:0]   sequence_length;
      logic [PARTIAL_W-1:0] partial_value;
   } seq_state_type;

   typedef struct packed {
      logic [CODE_W-1:0] code_point;
      status_type        status;
      logic              overlong;
      logic              end_of_string;
   } result_type;

   typedef struct packed {
      logic          emit;
      result_type    result;
      seq_state_type next_state;
   } step_out_type;

endpackage

`default_nettype wire

### rtl/u8d_req_if.sv
// Input byte channel: valid/ready handshake with one raw byte per transfer.
// Depends on u8d_pkg for field widths.
`default_nettype none

interface u8d_req_if;
   logic                        valid;
   logic                        ready;
   logic [u8d_pkg::BYTE_W-1:0]  byte_value;
   logic                        last_byte;

   modport source (output valid, output byte_value, output last_byte, input ready);
   modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

`default_nettype wire

### rtl/u8d_rsp_if.sv
// Result channel: valid/ready handshake with one decoded code point per transfer.
// Depends on u8d_pkg for field widths.
`default_nettype none

interface u8d_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [u8d_pkg::CODE_W-1:0]  code_point;
   logic [1:0]                  status;
   logic                        overlong;
   logic                        end_of_string;

   modport source (output valid, output code_point, output status, output overlong,
                   output end_of_string, input ready);
   modport sink   (input valid, input code_point, input status, input overlong,
                   input end_of_string, output ready);
endinterface

`default_nettype wire

### rtl/utf8_byte_decoder_core.sv
// Top level of the UTF-8 byte decoder: input register, sequence state, result register, CSR.
// Depends on u8d_pkg, u8d_req_if, u8d_rsp_if and u8d_step.
//
//   channel   direction  transfer payload
//   req_chan  in         byte_value[7:0], last_byte
//   rsp_chan  out        code_point[31:0], status[1:0], overlong, end_of_string
//   csr_*     in/out     APB, replacement_code at byte address 0
//
// One byte per cycle sustained unless a full, stalled result register holds a byte back: a
// byte waits in the input register, then one pass of decode logic updates the sequence
// state and loads the result register, which drives rsp valid.
// A byte that completes no code point retires without touching the result register.
// A full, stalled result register holds back only bytes that produce a result.
// Reset clears the sequence state, both valid flags and sets replacement_code to 0xFFFD.
`default_nettype none

module utf8_byte_decoder_core (
   input  wire  logic                              clock,
   input  wire  logic                              reset,
   u8d_req_if.sink                                 req_chan,
   u8d_rsp_if.source                               rsp_chan,
   input  wire  logic                              csr_psel,
   input  wire  logic                              csr_penable,
   input  wire  logic                              csr_pwrite,
   input  wire  logic [u8d_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire  logic [u8d_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output       logic [u8d_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output       logic                              csr_pready
);

   logic                            in_valid_ff, in_valid_in;
   logic [u8d_pkg::BYTE_W-1:0]      in_byte_ff, in_byte_in;
   logic                            in_last_ff, in_last_in;
   u8d_pkg::seq_state_type          state_ff, state_in;
   logic                            out_valid_ff, out_valid_in;
   u8d_pkg::result_type             out_ff, out_in;
   logic [u8d_pkg::CODE_W-1:0]      replacement_ff, replacement_in;

   u8d_pkg::step_out_type           step_out;
   logic                            out_free;
   logic                            advance;
   logic                            csr_write;
   logic                            csr_hit;

   u8d_step u_step (
      .state            (state_ff),
      .byte_value       (in_byte_ff),
      .last_byte        (in_last_ff),
      .replacement_code (replacement_ff),
      .step_out         (step_out)
   );

   assign out_free       = !out_valid_ff || rsp_chan.ready;
   assign advance        = in_valid_ff && (!step_out.emit || out_free);
   assign req_chan.ready = !in_valid_ff || advance;

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.code_point    = out_ff.code_point;
   assign rsp_chan.status        = out_ff.status;
   assign rsp_chan.overlong      = out_ff.overlong;
   assign rsp_chan.end_of_string = out_ff.end_of_string;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[2] == u8d_pkg::REG_REPLACEMENT);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit;
   assign csr_prdata = csr_hit ? replacement_ff : '0;

   always_comb begin
      in_valid_in    = in_valid_ff;
      in_byte_in     = in_byte_ff;
      in_last_in     = in_last_ff;
      state_in       = state_ff;
      out_valid_in   = out_valid_ff;
      out_in         = out_ff;
      replacement_in = replacement_ff;

      if (req_chan.ready) begin
         in_valid_in = req_chan.valid;
         in_byte_in  = req_chan.byte_value;
         in_last_in  = req_chan.last_byte;
      end
      if (advance) begin
         state_in = step_out.next_state;
      end
      if (advance && step_out.emit) begin
         out_valid_in = 1'b1;
         out_in       = step_out.result;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
      if (csr_write) begin
         replacement_in = csr_pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         state_ff       <= '0;
         out_valid_ff   <= 1'b0;
         replacement_ff <= u8d_pkg::REPLACEMENT_RESET;
      end else begin
         in_valid_ff    <= in_valid_in;
         state_ff       <= state_in;
         out_valid_ff   <= out_valid_in;
         replacement_ff <= replacement_in;
      end
      in_byte_ff <= in_byte_in;
      in_last_ff <= in_last_in;
      out_ff     <= out_in;
   end

`ifndef NO_ASSERTIONS
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.bytes_remaining <= 3'd5)
      else $error("bytes_remaining out of range");

   a_len_covers_rem: assert property (@(posedge clock) disable iff (reset)
      state_ff.bytes_remaining != '0 |-> state_ff.sequence_length > state_ff.bytes_remaining)
      else $error("sequence_length not above bytes_remaining");

   a_truncated_shape: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.status == u8d_pkg::STATUS_TRUNCATED
      |-> out_ff.end_of_string && out_ff.code_point == '0 && !out_ff.overlong)
      else $error("truncated result malformed");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_chan.ready |=> out_valid_ff && $stable(out_ff))
      else $error("stalled result overwritten");

   a_no_emit_lost: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && step_out.emit && out_valid_ff && !rsp_chan.ready |-> !advance)
      else $error("result dropped on full output register");
`endif

endmodule

`default_nettype wire

### rtl/u8d_step.sv
// Combinational decode of one byte against the current sequence state.
// Depends on u8d_pkg; instantiated by utf8_byte_decoder_core.
`default_nettype none

module u8d_step (
   input  wire  u8d_pkg::seq_state_type          state,
   input  wire  logic [u8d_pkg::BYTE_W-1:0]      byte_value,
   input  wire  logic                            last_byte,
   input  wire  logic [u8d_pkg::CODE_W-1:0]      replacement_code,
   output       u8d_pkg::step_out_type           step_out
);

   function automatic logic [u8d_pkg::COUNT_W-1:0] min_len(
      input logic [u8d_pkg::PARTIAL_W-1:0] v
   );
      logic [u8d_pkg::COUNT_W-1:0] n;
      begin
         if (v[30:7] == '0) begin
            n = 3'd1;
         end else if (v[30:11] == '0) begin
            n = 3'd2;
         end else if (v[30:16] == '0) begin
            n = 3'd3;
         end else if (v[30:21] == '0) begin
            n = 3'd4;
         end else if (v[30:26] == '0) begin
            n = 3'd5;
         end else begin
            n = 3'd6;
         end
         return n;
      end
   endfunction

   logic [u8d_pkg::PARTIAL_W-1:0] shifted;
   logic [u8d_pkg::COUNT_W-1:0]   rem_dec;
   logic [u8d_pkg::COUNT_W-1:0]   extra;
   logic [u8d_pkg::PARTIAL_W-1:0] lead_bits;
   logic                          is_lead;
   logic                          is_invalid;

   localparam u8d_pkg::seq_state_type CLEAR_STATE = '0;

   assign shifted = {state.partial_value[u8d_pkg::PARTIAL_W-7:0], byte_value[5:0]};
   assign rem_dec = state.bytes_remaining - 3'd1;

   always_comb begin
      extra      = '0;
      lead_bits  = '0;
      is_lead    = 1'b0;
      is_invalid = 1'b0;
      unique casez (byte_value)
         8'b1111_111?: begin
            is_invalid = 1'b1;
         end
         8'b1111_110?: begin
            is_lead   = 1'b1;
            extra     = 3'd5;
            lead_bits = {30'b0, byte_value[0]};
         end
         8'b1111_10??: begin
            is_lead   = 1'b1;
            extra     = 3'd4;
            lead_bits = {29'b0, byte_value[1:0]};
         end
         8'b1111_0???: begin
            is_lead   = 1'b1;
            extra     = 3'd3;
            lead_bits = {28'b0, byte_value[2:0]};
         end
         8'b1110_????: begin
            is_lead   = 1'b1;
            extra     = 3'd2;
            lead_bits = {27'b0, byte_value[3:0]};
         end
         8'b110?_????: begin
            is_lead   = 1'b1;
            extra     = 3'd1;
            lead_bits = {26'b0, byte_value[4:0]};
         end
         default: begin
            is_lead = 1'b0;
         end
      endcase
   end

   always_comb begin
      step_out                      = '0;
      step_out.next_state           = state;
      step_out.result.status        = u8d_pkg::STATUS_OK;
      step_out.result.end_of_string = last_byte;
      if (state.bytes_remaining != '0) begin
         if (rem_dec == '0) begin
            step_out.emit              = 1'b1;
            step_out.result.code_point = {1'b0, shifted};
            step_out.result.overlong   = (min_len(shifted) < state.sequence_length);
            step_out.next_state        = CLEAR_STATE;
         end else if (last_byte) begin
            step_out.emit                 = 1'b1;
            step_out.result.status        = u8d_pkg::STATUS_TRUNCATED;
            step_out.result.end_of_string = 1'b1;
            step_out.next_state           = CLEAR_STATE;
         end else begin
            step_out.next_state.bytes_remaining = rem_dec;
            step_out.next_state.partial_value   = shifted;
         end
      end else if (is_invalid) begin
         step_out.emit              = 1'b1;
         step_out.result.code_point = replacement_code;
         step_out.result.status     = u8d_pkg::STATUS_INVALID;
      end else if (is_lead) begin
         if (last_byte) begin
            step_out.emit                 = 1'b1;
            step_out.result.status        = u8d_pkg::STATUS_TRUNCATED;
            step_out.result.end_of_string = 1'b1;
            step_out.next_state           = CLEAR_STATE;
         end else begin
            step_out.next_state.bytes_remaining = extra;
            step_out.next_state.sequence_length = extra + 3'd1;
            step_out.next_state.partial_value   = lead_bits;
         end
      end else begin
         step_out.emit              = 1'b1;
         step_out.result.code_point = {25'b0, byte_value[6:0]};
      end
   end

endmodule

`default_nettype wire
